FILE: rtl/lrs_pkg.sv
// Package for the line raster stepper: widths, codes and the structs that
// travel between the front end, the command queue and the step engine.
// Depends on nothing.
package lrs_pkg;

	localparam int COORD_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int FRAME_BITS = 15;
	localparam int COLOR_BITS = 24;
	localparam int MINOR_BITS = COORD_BITS + 1;
	localparam int DIAG_BITS  = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int CMP_BITS   = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS + 1;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [FIELD_BITS-1:0] field_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [FRAME_BITS-1:0] frame_dim_t;

	typedef struct packed {
		frame_dim_t width;
		frame_dim_t height;
	} frame_t;

	typedef struct packed {
		logic                         is_load;
		coord_t                       start_x;
		coord_t                       start_y;
		coord_t                       major_end;
		logic signed [MINOR_BITS-1:0] minor_inc;
		logic signed [DIAG_BITS-1:0]  diag_inc;
		logic                         y_down;
		logic                         steep;
		color_t                       color;
	} cmd_t;

	typedef struct packed {
		logic   write_valid;
		field_t pixel_x;
		field_t pixel_y;
		color_t pixel_color;
		logic   line_last;
	} res_t;

endpackage

FILE: rtl/lrs_front.sv
// Front end of the line raster stepper: classifies a request and, for a load,
// saturates and orders the endpoints and works out the walk setup.
// Depends on lrs_pkg.
module lrs_front (
	input  logic                   action,
	input  logic signed [15:0]     start_x,
	input  logic signed [15:0]     start_y,
	input  logic signed [15:0]     end_x,
	input  logic signed [15:0]     end_y,
	input  logic [23:0]            draw_color,
	output lrs_pkg::cmd_t          cmd
);
	import lrs_pkg::*;

	localparam field_t SAT_HI = FIELD_BITS'((1 << (COORD_BITS - 1)) - 1);
	localparam field_t SAT_LO = -SAT_HI - field_t'(1);

	function automatic coord_t sat_coord(input field_t v);
		coord_t r;
		if (v > SAT_HI) begin
			r = COORD_BITS'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = COORD_BITS'(SAT_LO);
		end else begin
			r = COORD_BITS'(v);
		end
		return r;
	endfunction

	coord_t sx1, sy1, sx2, sy2;
	coord_t x1, y1, x2, y2;
	logic swap, y_down, steep;
	logic signed [MINOR_BITS-1:0] dx, ady, minor_d, major_d;

	always_comb begin
		sx1 = sat_coord(start_x);
		sy1 = sat_coord(start_y);
		sx2 = sat_coord(end_x);
		sy2 = sat_coord(end_y);
		swap = sx2 < sx1;
		x1 = swap ? sx2 : sx1;
		y1 = swap ? sy2 : sy1;
		x2 = swap ? sx1 : sx2;
		y2 = swap ? sy1 : sy2;
		dx = MINOR_BITS'(x2) - MINOR_BITS'(x1);
		y_down = y2 < y1;
		ady = y_down ? (MINOR_BITS'(y1) - MINOR_BITS'(y2)) : (MINOR_BITS'(y2) - MINOR_BITS'(y1));
		// Ties between the two deltas take the shallow walk.
		steep = dx < ady;
		minor_d = steep ? dx : ady;
		major_d = steep ? ady : dx;

		cmd.is_load   = (action == ACT_LOAD);
		cmd.start_x   = x1;
		cmd.start_y   = y1;
		cmd.major_end = steep ? y2 : x2;
		cmd.minor_inc = minor_d;
		cmd.diag_inc  = DIAG_BITS'(minor_d) - DIAG_BITS'(major_d);
		cmd.y_down    = y_down;
		cmd.steep     = steep;
		cmd.color     = draw_color;
	end

endmodule

FILE: rtl/lrs_cmd_queue.sv
// Two-entry command queue between the front end and the step engine.
// Depends on lrs_pkg.
module lrs_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lrs_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output lrs_pkg::cmd_t rd_cmd
);
	import lrs_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: rtl/lrs_back.sv
// Step engine of the line raster stepper: holds the walk state, turns each
// command into one result and queues results in a two-entry output queue.
// Depends on lrs_pkg.
module lrs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lrs_pkg::frame_t frame,
	input  logic            cmd_valid,
	input  lrs_pkg::cmd_t   cmd,
	output logic            cmd_take,
	input  logic            res_pop,
	output logic            res_empty,
	output lrs_pkg::res_t   res
);
	import lrs_pkg::*;

	coord_t                       walk_x_q, walk_y_q, major_end_q;
	logic signed [ERR_BITS-1:0]   error_q;
	logic signed [MINOR_BITS-1:0] minor_inc_q;
	logic signed [DIAG_BITS-1:0]  diag_inc_q;
	logic                         y_down_q, steep_q, active_q;
	color_t                       color_q;

	res_t       res_entry_q [2];
	logic       res_wr_ptr_q, res_rd_ptr_q;
	logic [1:0] res_count_q;

	res_t   new_res;
	logic   in_frame, last, fire, res_pushed, res_taken;
	coord_t major, y_next;
	logic [CMP_BITS-1:0] x_u, y_u;

	assign res_taken = res_pop && (res_count_q != 2'd0);
	assign fire      = cmd_valid && (res_count_q != 2'd2);
	assign cmd_take  = fire;
	assign res_pushed = fire;
	assign res_empty = (res_count_q == 2'd0);
	assign res       = res_entry_q[res_rd_ptr_q];

	always_comb begin
		x_u = CMP_BITS'(unsigned'(walk_x_q));
		y_u = CMP_BITS'(unsigned'(walk_y_q));
		in_frame = !walk_x_q[COORD_BITS-1] && !walk_y_q[COORD_BITS-1]
			&& (x_u < CMP_BITS'(frame.width)) && (y_u < CMP_BITS'(frame.height));
		major  = steep_q ? walk_y_q : walk_x_q;
		last   = (major == major_end_q);
		y_next = y_down_q ? (walk_y_q - coord_t'(1)) : (walk_y_q + coord_t'(1));

		new_res = '0;
		if (!cmd.is_load && active_q) begin
			new_res.write_valid = in_frame;
			new_res.pixel_x     = FIELD_BITS'(walk_x_q);
			new_res.pixel_y     = FIELD_BITS'(walk_y_q);
			new_res.pixel_color = color_q;
			new_res.line_last   = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			major_end_q <= '0;
			error_q     <= '0;
			minor_inc_q <= '0;
			diag_inc_q  <= '0;
			y_down_q    <= 1'b0;
			steep_q     <= 1'b0;
			active_q    <= 1'b0;
			color_q     <= '0;
		end else if (fire) begin
			if (cmd.is_load) begin
				walk_x_q    <= cmd.start_x;
				walk_y_q    <= cmd.start_y;
				major_end_q <= cmd.major_end;
				minor_inc_q <= cmd.minor_inc;
				diag_inc_q  <= cmd.diag_inc;
				error_q     <= ERR_BITS'(cmd.diag_inc);
				y_down_q    <= cmd.y_down;
				steep_q     <= cmd.steep;
				color_q     <= cmd.color;
				active_q    <= 1'b1;
			end else if (active_q) begin
				if (last) begin
					active_q <= 1'b0;
				end else begin
					if (error_q < 0) begin
						error_q <= error_q + ERR_BITS'(minor_inc_q);
					end else begin
						error_q <= error_q + ERR_BITS'(diag_inc_q);
					end
					if (steep_q) begin
						walk_y_q <= y_next;
						if (!(error_q < 0)) begin
							walk_x_q <= walk_x_q + coord_t'(1);
						end
					end else begin
						walk_x_q <= walk_x_q + coord_t'(1);
						if (!(error_q < 0)) begin
							walk_y_q <= y_next;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= 1'b0;
			res_rd_ptr_q <= 1'b0;
			res_count_q  <= 2'd0;
		end else begin
			if (res_pushed) begin
				res_wr_ptr_q <= ~res_wr_ptr_q;
			end
			if (res_taken) begin
				res_rd_ptr_q <= ~res_rd_ptr_q;
			end
			res_count_q <= res_count_q + {1'b0, res_pushed} - {1'b0, res_taken};
		end
	end

	always_ff @(posedge clk) begin
		if (res_pushed) begin
			res_entry_q[res_wr_ptr_q] <= new_res;
		end
	end

endmodule

FILE: rtl/line_raster_stepper.sv
// Top level of the line raster stepper; depends on lrs_pkg, lrs_front, lrs_cmd_queue, lrs_back.
// A request accepted into the command queue is taken by the step engine, which writes its result
// into the result queue for the result ports; a full result queue holds the command back.
// Throughput: one request per cycle while results are popped as they come; the step engine
// waits whenever its two-entry result queue is full, even in a cycle that pops it.
// Reset (arst_n low) idles the walk, empties both queues and sets the frame to 640 by 480.
module line_raster_stepper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [23:0]        draw_color,
	output logic               empty,
	input  logic               pop,
	output logic               write_valid,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [23:0]        pixel_color,
	output logic               line_last,
	input  logic               write_enable,
	input  logic [1:0]         write_index,
	input  logic [14:0]        write_data
);
	import lrs_pkg::*;

	// Frame size registers. A write to an index beyond the list is dropped.
	frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q.width  <= FRAME_BITS'(640);
			frame_q.height <= FRAME_BITS'(480);
		end else if (write_enable) begin
			unique case (write_index)
				REG_FRAME_WIDTH:  frame_q.width  <= write_data;
				REG_FRAME_HEIGHT: frame_q.height <= write_data;
				default: ;
			endcase
		end
	end

	// The front end is purely combinational: it turns the request into a
	// command, which is written into the queue when the request is accepted.
	cmd_t front_cmd, queue_cmd;
	logic accept, queue_valid, queue_take;
	res_t res;

	assign accept = push && !full;

	lrs_front u_front (
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.draw_color (draw_color),
		.cmd        (front_cmd)
	);

	// The queue lets the front keep accepting while the step engine waits on
	// a full result queue, and the other way around.
	lrs_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (queue_take),
		.rd_valid (queue_valid),
		.rd_cmd   (queue_cmd)
	);

	// The step engine executes one command per cycle whenever its result
	// queue has room, so a steady pop each cycle keeps the block at full rate.
	lrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_q),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_take  (queue_take),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign write_valid = res.write_valid;
	assign pixel_x     = res.pixel_x;
	assign pixel_y     = res.pixel_y;
	assign pixel_color = res.pixel_color;
	assign line_last   = res.line_last;

endmodule

FILE: tb/line_raster_stepper_tb.sv
// Self-checking testbench for line_raster_stepper: load and step requests go in
// through the input queue, and each pixel result is checked against a predictor.
// Depends on lrs_pkg and the line_raster_stepper RTL; reads no files.
module line_raster_stepper_tb;
	import lrs_pkg::*;

	// Any stretch this long with no request, result or register write is a hang.
	localparam int STALL_LIMIT = 5000;
	// A request is registered in both queues on its way out; this leaves margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOW_LIMIT = 10;
	localparam int IDLE_PERCENT = 36;
	// Indexes past the register list; writes to them must change nothing.
	localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 2'd3;
	localparam res_t NO_PIXEL = '0;

	typedef struct {
		logic   action;
		field_t sx;
		field_t sy;
		field_t ex;
		field_t ey;
		color_t color;
	} request_t;

	// One row of the directed part. When typed is set, want is the result read
	// straight off the spec; otherwise the predictor supplies it.
	typedef struct {
		request_t req;
		logic     typed;
		res_t     want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               action = ACT_LOAD;
	field_t             start_x = '0;
	field_t             start_y = '0;
	field_t             end_x = '0;
	field_t             end_y = '0;
	color_t             draw_color = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic               write_valid;
	field_t             pixel_x;
	field_t             pixel_y;
	color_t             pixel_color;
	logic               line_last;
	logic               write_enable = 1'b0;
	logic [IDX_BITS-1:0] write_index = REG_FRAME_WIDTH;
	frame_dim_t         write_data = '0;

	line_raster_stepper uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the walk as the block should hold it, at the block's widths.
	coord_t                       trk_x = '0;
	coord_t                       trk_y = '0;
	coord_t                       trk_end = '0;
	logic signed [ERR_BITS-1:0]   trk_err = '0;
	logic signed [MINOR_BITS-1:0] trk_minor = '0;
	logic signed [DIAG_BITS-1:0]  trk_diag = '0;
	logic                         trk_down = 1'b0;
	logic                         trk_steep = 1'b0;
	logic                         trk_busy = 1'b0;
	color_t                       trk_color = '0;
	frame_dim_t                   frm_w = 15'd640;
	frame_dim_t                   frm_h = 15'd480;

	res_t     pixels_due[$];
	dir_row_t dir_rows[$];
	int       fails = 0;
	int       idle_cycles = 0;
	// When set, the sender or the receiver never idles.
	logic     tx_steady = 1'b0;
	logic     rx_steady = 1'b0;

	// Applies one request to the predicted walk and returns the pixel it yields.
	// Loads and steps while idle yield an all-zero result.
	function automatic res_t rasterize(request_t r);
		res_t   o;
		int     x1, y1, x2, y2, t, dx, ady;
		logic   in_frame, at_end, minor_move;
		coord_t ystep;
		o = NO_PIXEL;
		if (r.action == ACT_LOAD) begin
			// 16-bit fields already sit inside the 16-bit coordinate range, so
			// saturation on load never bites at this configuration.
			x1 = r.sx;
			y1 = r.sy;
			x2 = r.ex;
			y2 = r.ey;
			// Walk with x rising: swap the endpoints when the line runs leftward.
			if (x2 < x1) begin
				t = x1;
				x1 = x2;
				x2 = t;
				t = y1;
				y1 = y2;
				y2 = t;
			end
			dx = x2 - x1;
			trk_down = y2 < y1;
			ady = trk_down ? y1 - y2 : y2 - y1;
			// A tie between the two deltas stays on the shallow walk.
			trk_steep = dx < ady;
			trk_x = coord_t'(x1);
			trk_y = coord_t'(y1);
			trk_end = coord_t'(trk_steep ? y2 : x2);
			trk_minor = MINOR_BITS'(trk_steep ? dx : ady);
			trk_diag = DIAG_BITS'(trk_steep ? dx - ady : ady - dx);
			trk_err = ERR_BITS'(trk_diag);
			trk_color = r.color;
			trk_busy = 1'b1;
			return o;
		end
		if (!trk_busy)
			return o;
		in_frame = int'(trk_x) >= 0 && int'(trk_y) >= 0 &&
			int'(trk_x) < int'(frm_w) && int'(trk_y) < int'(frm_h);
		at_end = (trk_steep ? trk_y : trk_x) == trk_end;
		o.write_valid = in_frame;
		o.pixel_x = trk_x;
		o.pixel_y = trk_y;
		o.pixel_color = trk_color;
		o.line_last = at_end;
		if (at_end) begin
			trk_busy = 1'b0;
			return o;
		end
		ystep = trk_down ? -16'sd1 : 16'sd1;
		if (trk_err < 0) begin
			trk_err = trk_err + ERR_BITS'(trk_minor);
			minor_move = 1'b0;
		end else begin
			trk_err = trk_err + ERR_BITS'(trk_diag);
			minor_move = 1'b1;
		end
		if (trk_steep) begin
			trk_y = trk_y + ystep;
			if (minor_move)
				trk_x = trk_x + 16'sd1;
		end else begin
			trk_x = trk_x + 16'sd1;
			if (minor_move)
				trk_y = trk_y + ystep;
		end
		return o;
	endfunction

	function automatic void note_fail(string msg);
		fails++;
		if (fails <= SHOW_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic field_t clamp16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return field_t'(v);
	endfunction

	function automatic request_t load_req(int sx, int sy, int ex, int ey, color_t c);
		request_t r;
		r.action = ACT_LOAD;
		r.sx = field_t'(sx);
		r.sy = field_t'(sy);
		r.ex = field_t'(ex);
		r.ey = field_t'(ey);
		r.color = c;
		return r;
	endfunction

	// A step with random junk in the fields the block ignores on a step.
	function automatic request_t step_req();
		request_t r;
		r.action = ACT_STEP;
		r.sx = field_t'($urandom);
		r.sy = field_t'($urandom);
		r.ex = field_t'($urandom);
		r.ey = field_t'($urandom);
		r.color = color_t'($urandom);
		return r;
	endfunction

	// Coordinates mostly land around the frame so both clipped and written
	// pixels show up; some sit at the ends of the 16-bit range, some anywhere.
	function automatic field_t pick_coord(int dim);
		int roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return clamp16(int'($urandom_range(dim + 12)) - 6);
		if (roll < 85)
			return $urandom_range(1) ? clamp16(32767 - int'($urandom_range(7)))
				: clamp16(-32768 + int'($urandom_range(7)));
		return field_t'($urandom);
	endfunction

	function automatic void add_row(request_t r, logic typed, res_t want);
		dir_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// Result side: pop is redrawn every cycle, and a result is taken at an edge
	// where pop and a non-empty queue were both seen. Sampling happens before
	// this edge's updates land, so the values are the ones the handshake moved.
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && pop && !empty) begin
			got = {write_valid, pixel_x, pixel_y, pixel_color, line_last};
			if (pixels_due.size() == 0) begin
				note_fail($sformatf("result with nothing pending: x=%0d y=%0d",
					got.pixel_x, got.pixel_y));
			end else begin
				want = pixels_due.pop_front();
				if (got.write_valid !== want.write_valid || got.pixel_x !== want.pixel_x ||
					got.pixel_y !== want.pixel_y || got.pixel_color !== want.pixel_color ||
					got.line_last !== want.line_last)
					note_fail($sformatf({"pixel mismatch: expected v=%0b x=%0d y=%0d c=%06h ",
						"last=%0b, got v=%0b x=%0d y=%0d c=%06h last=%0b"},
						want.write_valid, want.pixel_x, want.pixel_y, want.pixel_color,
						want.line_last, got.write_valid, got.pixel_x, got.pixel_y,
						got.pixel_color, got.line_last));
			end
		end
		pop <= rx_steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Watchdog: restarts on any accepted request, accepted result or register
	// write, so a slow but correct run never trips it.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || write_enable)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Presents one request, with random idle cycles in front of it, and returns
	// at the edge where it was taken. The caller is always at a rising edge, and
	// each path drives push exactly once per edge.
	task automatic offer(request_t r, logic typed, res_t want);
		res_t pred;
		while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= r.action;
		start_x <= r.sx;
		start_y <= r.sy;
		end_x <= r.ex;
		end_y <= r.ey;
		draw_color <= r.color;
		@(posedge clk);
		while (full)
			@(posedge clk);
		// The predictor must advance even where the row carries its own answer.
		pred = rasterize(r);
		pixels_due.push_back(typed ? want : pred);
	endtask

	// Stops sending and waits for every pending result, then lets the pipeline
	// settle; the block is idle afterwards and registers may be written.
	task automatic drain();
		push <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes both frame registers, then a spare index that has to be ignored.
	task automatic set_frame(frame_dim_t w, frame_dim_t h, logic [IDX_BITS-1:0] spare);
		write_enable <= 1'b1;
		write_index <= REG_FRAME_WIDTH;
		write_data <= w;
		@(posedge clk);
		write_index <= REG_FRAME_HEIGHT;
		write_data <= h;
		@(posedge clk);
		write_index <= spare;
		write_data <= frame_dim_t'($urandom);
		@(posedge clk);
		write_enable <= 1'b0;
		frm_w = w;
		frm_h = h;
	endtask

	// Random traffic, mostly whole lines: a load followed by about as many steps
	// as the line has pixels. Some lines get extra steps that land on an idle
	// walker, some are cut short by the next load, and a few requests are pure
	// noise. Lines between far endpoints are always cut short.
	task automatic run_lines(int n);
		request_t r;
		int done, dx, dy, span, steps;
		done = 0;
		while (done < n) begin
			if ($urandom_range(99) < 8) begin
				r = step_req();
				r.action = logic'($urandom_range(1));
				offer(r, 1'b0, NO_PIXEL);
				done++;
				continue;
			end
			r.action = ACT_LOAD;
			r.sx = pick_coord(int'(frm_w));
			r.sy = pick_coord(int'(frm_h));
			if ($urandom_range(99) < 85) begin
				r.ex = clamp16(int'(r.sx) + int'($urandom_range(48)) - 24);
				r.ey = clamp16(int'(r.sy) + int'($urandom_range(48)) - 24);
			end else begin
				r.ex = pick_coord(int'(frm_w));
				r.ey = pick_coord(int'(frm_h));
			end
			r.color = color_t'($urandom);
			offer(r, 1'b0, NO_PIXEL);
			done++;
			dx = int'(r.ex) - int'(r.sx);
			dy = int'(r.ey) - int'(r.sy);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			span = (dx > dy ? dx : dy) + 1;
			if ($urandom_range(99) < 75)
				steps = span + int'($urandom_range(2));
			else
				steps = int'($urandom_range(span - 1));
			if (steps > 48)
				steps = 48;
			repeat (steps) begin
				offer(step_req(), 1'b0, NO_PIXEL);
				done++;
			end
		end
	endtask

	initial begin
		// Directed rows. Loads and steps on an idle walker must give all zeros;
		// one-pixel lines are simple enough to spell out.
		add_row(step_req(), 1'b1, NO_PIXEL);
		// Shallow line, rising y.
		add_row(load_req(0, 0, 3, 1, 24'hffffff), 1'b1, NO_PIXEL);
		repeat (4)
			add_row(step_req(), 1'b0, NO_PIXEL);
		add_row(step_req(), 1'b1, NO_PIXEL);
		// Endpoints swapped so x rises; steep, y falling. Cut short by the next load.
		add_row(load_req(5, -2, 2, 6, 24'h123456), 1'b1, NO_PIXEL);
		repeat (2)
			add_row(step_req(), 1'b0, NO_PIXEL);
		// Corner to corner of the coordinate range: tie, clipped pixels.
		add_row(load_req(-32768, -32768, 32767, 32767, 24'h000000), 1'b1, NO_PIXEL);
		repeat (2)
			add_row(step_req(), 1'b0, NO_PIXEL);
		// One-pixel line at the extreme corner, outside the frame.
		add_row(load_req(32767, -32768, 32767, -32768, 24'h5a5a5a), 1'b1, NO_PIXEL);
		add_row(step_req(), 1'b1, '{write_valid: 1'b0, pixel_x: 16'sh7fff,
			pixel_y: 16'sh8000, pixel_color: 24'h5a5a5a, line_last: 1'b1});
		// One-pixel line inside the frame.
		add_row(load_req(5, 7, 5, 7, 24'habcdef), 1'b1, NO_PIXEL);
		add_row(step_req(), 1'b1, '{write_valid: 1'b1, pixel_x: 16'sd5,
			pixel_y: 16'sd7, pixel_color: 24'habcdef, line_last: 1'b1});
		// Diagonal tie with y falling.
		add_row(load_req(0, 0, 2, -2, 24'h00ff00), 1'b1, NO_PIXEL);
		repeat (3)
			add_row(step_req(), 1'b0, NO_PIXEL);
		// Vertical line on the last column and row of the default frame.
		add_row(load_req(639, 479, 639, 478, 24'h800001), 1'b1, NO_PIXEL);
		repeat (2)
			add_row(step_req(), 1'b0, NO_PIXEL);
		add_row(step_req(), 1'b1, NO_PIXEL);

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs on the frame left by reset, 640 by 480.
		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// Every phase change drains the block first, so the sender also pauses
		// until nothing is pending, mid-line as often as not.
		drain();
		// Empty frame: every pixel is clipped.
		set_frame(15'd0, 15'd0, REG_SPARE_LO);
		run_lines(100);
		drain();
		set_frame(15'h7fff, 15'h7fff, REG_SPARE_HI);
		run_lines(100);
		drain();
		// Small frame, both sides running flat out.
		set_frame(15'd16, 15'd12, REG_SPARE_LO);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_lines(120);
		drain();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		set_frame(15'd1, 15'd1, REG_SPARE_HI);
		run_lines(100);
		drain();
		set_frame(frame_dim_t'($urandom), frame_dim_t'($urandom), REG_SPARE_LO);
		run_lines(100);
		drain();
		set_frame(15'd640, 15'd480, REG_SPARE_HI);
		run_lines(180);
		drain();

		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lrs_pkg.sv
rtl/lrs_front.sv
rtl/lrs_cmd_queue.sv
rtl/lrs_back.sv
rtl/line_raster_stepper.sv
tb/line_raster_stepper_tb.sv
